@@ sv/fiv_pkg.sv @@
package fiv_pkg;

  localparam int DATE_BYTES = 12;
  localparam int HDR_LEN    = DATE_BYTES + 8;

  // Header byte offsets, little-endian fields
  localparam int SW_AT = 0;
  localparam int SC_AT = DATE_BYTES + 2;
  localparam int HW_AT = DATE_BYTES + 6;

  localparam int LEN_W = 24;
  localparam int CNT_W = 32;
  localparam int CRC_W = 32;
  localparam int VER_W = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // Configuration port: 32-bit data, one register (24 bits used), selected by paddr[2]
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ORIG_LEN = 1'b0;
  localparam logic [LEN_W-1:0] ORIG_LEN_RESET = 24'd1;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_HEADER  = 3'd1,
    ST_SHORT_PAYLOAD = 3'd2,
    ST_CRC_MISMATCH  = 3'd3,
    ST_PAYLOAD_DIFF  = 3'd4,
    ST_PADDING_DIRTY = 3'd5
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [VER_W-1:0]   sw_version;
    logic [VER_W-1:0]   hw_version;
    logic [CRC_W-1:0]   stored_crc;
    logic [CRC_W-1:0]   computed_crc;
    logic [CNT_W-1:0]   padding_count;
    logic [CNT_W-1:0]   packed_count;
  } result_t;

  // Reflected CRC-32, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/fiv_core.sv @@
module fiv_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      beat,
  input  logic [7:0]                packed_byte,
  input  logic [7:0]                original_byte,
  input  logic                      final_byte,
  input  logic [fiv_pkg::LEN_W-1:0] orig_len,
  output logic                      res_valid,
  output fiv_pkg::result_t          res
);

  logic [fiv_pkg::CNT_W-1:0] pos_r;
  logic [fiv_pkg::CNT_W-1:0] pos_nxt;
  logic [fiv_pkg::CRC_W-1:0] crc_r;
  logic [fiv_pkg::CRC_W-1:0] crc_nxt;
  logic                      differs_r;
  logic                      differs_nxt;
  logic                      dirty_r;
  logic                      dirty_nxt;
  logic [7:0]                hdr_r [fiv_pkg::HDR_LEN];
  logic [7:0]                hdr_view [fiv_pkg::HDR_LEN];

  logic [fiv_pkg::CNT_W-1:0] need;
  logic                      in_hdr;
  logic                      in_pay;

  assign need   = fiv_pkg::CNT_W'(fiv_pkg::HDR_LEN) + fiv_pkg::CNT_W'(orig_len);
  assign in_hdr = pos_r < fiv_pkg::CNT_W'(fiv_pkg::HDR_LEN);
  assign in_pay = !in_hdr && (pos_r < need);

  assign pos_nxt     = (pos_r == fiv_pkg::CNT_MAX) ? pos_r : pos_r + 1'b1;
  assign crc_nxt     = in_pay ? fiv_pkg::crc_byte(crc_r, original_byte) : crc_r;
  assign differs_nxt = differs_r | (in_pay && (packed_byte != original_byte));
  assign dirty_nxt   = dirty_r | (!in_hdr && !in_pay && (packed_byte != 8'd0));

  // Header as seen including this beat's byte
  always_comb begin
    for (int i = 0; i < fiv_pkg::HDR_LEN; i++) begin
      hdr_view[i] = (pos_r == fiv_pkg::CNT_W'(i)) ? packed_byte : hdr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < fiv_pkg::HDR_LEN; i++) begin
      if (beat && (pos_r == fiv_pkg::CNT_W'(i))) begin
        hdr_r[i] <= packed_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && final_byte)) begin
      pos_r     <= '0;
      crc_r     <= fiv_pkg::CRC_INIT;
      differs_r <= 1'b0;
      dirty_r   <= 1'b0;
    end else if (beat) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      differs_r <= differs_nxt;
      dirty_r   <= dirty_nxt;
    end
  end

  assign res_valid = beat && final_byte;

  always_comb begin
    res = '0;
    res.packed_count = pos_nxt;
    if (pos_nxt < fiv_pkg::CNT_W'(fiv_pkg::HDR_LEN)) begin
      res.status = fiv_pkg::ST_SHORT_HEADER;
    end else begin
      res.sw_version = {hdr_view[fiv_pkg::SW_AT+1], hdr_view[fiv_pkg::SW_AT]};
      res.hw_version = {hdr_view[fiv_pkg::HW_AT+1], hdr_view[fiv_pkg::HW_AT]};
      res.stored_crc = {hdr_view[fiv_pkg::SC_AT+3], hdr_view[fiv_pkg::SC_AT+2],
                        hdr_view[fiv_pkg::SC_AT+1], hdr_view[fiv_pkg::SC_AT]};
      if (pos_nxt < need) begin
        res.status = fiv_pkg::ST_SHORT_PAYLOAD;
      end else begin
        res.computed_crc  = crc_nxt ^ fiv_pkg::CRC_INIT;
        res.padding_count = pos_nxt - need;
        if (res.stored_crc != res.computed_crc) begin
          res.status = fiv_pkg::ST_CRC_MISMATCH;
        end else if (differs_nxt) begin
          res.status = fiv_pkg::ST_PAYLOAD_DIFF;
        end else if (dirty_nxt) begin
          res.status = fiv_pkg::ST_PADDING_DIRTY;
        end else begin
          res.status = fiv_pkg::ST_OK;
        end
      end
    end
  end

endmodule

@@ sv/firmware_image_verifier.sv @@
// Firmware image verifier.
// Input channel (in_*): one beat per byte of the packed image, with the
// matching original byte alongside; in_final_byte marks the image's last beat.
// Result channel (out_*): one beat per image, issued for the final byte only,
// carrying status, header fields, stored and computed CRC-32, padding count
// and total packed byte count.
// Configuration (cfg_*): APB-style, pready always high; original_length at
// byte address 0. Write it only between images.
// Throughput: one byte per cycle while in_ready is high; the byte-wide CRC-32 update,
// the header capture and the compares all finish in the cycle a beat is accepted.
// Latency: the result beat is valid the cycle after the final byte's beat.
// Stalls: the result sits in the output register; in_ready stays high while
// that register is empty or is drained in the same cycle, otherwise input
// beats hold until out_ready returns.
// Reset: synchronous, active low; clears the stream state, sets
// original_length to 1 and empties the output register. After every final
// byte the stream state returns to its reset values for the next image.
module firmware_image_verifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_packed_byte,
  input  logic [7:0]                     in_original_byte,
  input  logic                           in_final_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [15:0]                    out_sw_version,
  output logic [15:0]                    out_hw_version,
  output logic [31:0]                    out_stored_crc,
  output logic [31:0]                    out_computed_crc,
  output logic [31:0]                    out_padding_count,
  output logic [31:0]                    out_packed_count,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fiv_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fiv_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fiv_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  logic [fiv_pkg::LEN_W-1:0] orig_len_r;
  logic                      out_valid_r;
  fiv_pkg::result_t          res_r;
  fiv_pkg::result_t          core_res;
  logic                      core_res_valid;
  logic                      in_beat;
  logic                      cfg_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == fiv_pkg::REG_ORIG_LEN);
  assign cfg_prdata = (cfg_paddr[2] == fiv_pkg::REG_ORIG_LEN) ?
                      fiv_pkg::CFG_DATA_W'(orig_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orig_len_r <= fiv_pkg::ORIG_LEN_RESET;
    end else if (cfg_wr) begin
      orig_len_r <= cfg_pwdata[fiv_pkg::LEN_W-1:0];
    end
  end

  // Take a new byte whenever the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  fiv_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat          (in_beat),
    .packed_byte   (in_packed_byte),
    .original_byte (in_original_byte),
    .final_byte    (in_final_byte),
    .orig_len      (orig_len_r),
    .res_valid     (core_res_valid),
    .res           (core_res)
  );

  // Output register: load on a final byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid) begin
      res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_sw_version    = res_r.sw_version;
  assign out_hw_version    = res_r.hw_version;
  assign out_stored_crc    = res_r.stored_crc;
  assign out_computed_crc  = res_r.computed_crc;
  assign out_padding_count = res_r.padding_count;
  assign out_packed_count  = res_r.packed_count;

  // A final byte always produces a result beat in the next cycle
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_final_byte |=> out_valid)
    else $error("final byte did not produce a result beat");

  // A clean image means the CRCs agree
  a_ok_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fiv_pkg::ST_OK) |-> out_stored_crc == out_computed_crc)
    else $error("status ok with CRC mismatch");

  // Short header reports a short count and no header fields
  a_short_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fiv_pkg::ST_SHORT_HEADER) |->
      (out_packed_count < 32'(fiv_pkg::HDR_LEN)) && (out_stored_crc == '0) &&
      (out_sw_version == '0))
    else $error("short header result is inconsistent");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

import fiv_pkg::*;

// One beat of the packed image stream as the sender offers it
typedef struct {
  logic [7:0] pb;
  logic [7:0] ob;
  bit         fin;
} image_beat_t;

// Reflected CRC-32, fed one data bit at a time, LSB first
function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] acc,
                                                input logic [7:0] data);
  logic fb;
  for (int i = 0; i < 8; i++) begin
    fb  = acc[0] ^ data[i];
    acc = acc >> 1;
    if (fb) acc = acc ^ CRC_POLY;
  end
  return acc;
endfunction

// Tracks the image being streamed and predicts the verdict for each final byte
class image_verdicts;
  logic [LEN_W-1:0] orig_len;
  logic [CNT_W-1:0] byte_pos;
  logic [7:0]       hdr_bytes [HDR_LEN];
  logic [CRC_W-1:0] crc_acc;
  bit               payload_bad;
  bit               pad_bad;
  result_t          verdicts_due [$];
  int               mismatches;

  function new();
    orig_len   = ORIG_LEN_RESET;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    byte_pos = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    crc_acc     = CRC_INIT;
    payload_bad = 1'b0;
    pad_bad     = 1'b0;
  endfunction

  function void flag(string what, logic [31:0] want, logic [31:0] seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t in %s: expected %h, got %h", $time, what, want, seen);
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction

  // Note one accepted input beat
  function void take_byte(logic [7:0] pb, logic [7:0] ob, bit fin);
    logic [CNT_W-1:0] need;
    result_t v;
    need = HDR_LEN + orig_len;
    if (byte_pos < HDR_LEN) begin
      hdr_bytes[byte_pos] = pb;
    end else if (byte_pos < need) begin
      crc_acc = crc32_step(crc_acc, ob);
      if (pb != ob) payload_bad = 1'b1;
    end else if (pb != 8'd0) begin
      pad_bad = 1'b1;
    end
    if (byte_pos != CNT_MAX) byte_pos++;
    if (!fin) return;

    v = '0;
    v.packed_count = byte_pos;
    if (byte_pos < HDR_LEN) begin
      v.status = ST_SHORT_HEADER;
    end else begin
      v.sw_version = {hdr_bytes[SW_AT+1], hdr_bytes[SW_AT]};
      v.stored_crc = {hdr_bytes[SC_AT+3], hdr_bytes[SC_AT+2],
                      hdr_bytes[SC_AT+1], hdr_bytes[SC_AT]};
      v.hw_version = {hdr_bytes[HW_AT+1], hdr_bytes[HW_AT]};
      if (byte_pos < need) begin
        v.status = ST_SHORT_PAYLOAD;
      end else begin
        v.computed_crc  = crc_acc ^ CRC_INIT;
        v.padding_count = byte_pos - need;
        if (v.stored_crc != v.computed_crc) v.status = ST_CRC_MISMATCH;
        else if (payload_bad)               v.status = ST_PAYLOAD_DIFF;
        else if (pad_bad)                   v.status = ST_PADDING_DIRTY;
        else                                v.status = ST_OK;
      end
    end
    verdicts_due.push_back(v);
    restart();
  endfunction

  // Check one accepted result beat against the oldest prediction
  function void match_verdict(result_t got);
    result_t want;
    if (verdicts_due.size() == 0) begin
      flag("unexpected result, packed_count", 32'd0, got.packed_count);
      return;
    end
    want = verdicts_due.pop_front();
    if (got.status !== want.status)
      flag("status", 32'(want.status), 32'(got.status));
    if (got.sw_version !== want.sw_version)
      flag("sw_version", 32'(want.sw_version), 32'(got.sw_version));
    if (got.hw_version !== want.hw_version)
      flag("hw_version", 32'(want.hw_version), 32'(got.hw_version));
    if (got.stored_crc !== want.stored_crc)
      flag("stored_crc", want.stored_crc, got.stored_crc);
    if (got.computed_crc !== want.computed_crc)
      flag("computed_crc", want.computed_crc, got.computed_crc);
    if (got.padding_count !== want.padding_count)
      flag("padding_count", want.padding_count, got.padding_count);
    if (got.packed_count !== want.packed_count)
      flag("packed_count", want.packed_count, got.packed_count);
  endfunction
endclass

module tb;

  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 45;   // input beats per phase, roughly
  localparam int MIN_IMAGES  = 2;    // keep results coming even with long images
  localparam int HOLD_CYCLES = 400;  // receiver hold-off that backs up the block
  localparam int STALL_LIMIT = 3000; // cycles with no beat on either channel
  localparam logic [CFG_ADDR_W-1:0] ORIG_LEN_ADDR = {REG_ORIG_LEN, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_packed_byte;
  logic [7:0]            in_original_byte;
  logic                  in_final_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_status;
  logic [15:0]           out_sw_version;
  logic [15:0]           out_hw_version;
  logic [31:0]           out_stored_crc;
  logic [31:0]           out_computed_crc;
  logic [31:0]           out_padding_count;
  logic [31:0]           out_packed_count;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  image_verdicts verdicts;
  image_beat_t   image_beats [$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_req      = 1'b0;
  int            stall_cycles  = 0;

  firmware_image_verifier i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packed_byte    (in_packed_byte),
    .in_original_byte  (in_original_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_sw_version    (out_sw_version),
    .out_hw_version    (out_hw_version),
    .out_stored_crc    (out_stored_crc),
    .out_computed_crc  (out_computed_crc),
    .out_padding_count (out_padding_count),
    .out_packed_count  (out_packed_count),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge; feed the predictor and check results
  always @(posedge clk) begin
    result_t got;
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready)
        verdicts.take_byte(in_packed_byte, in_original_byte, in_final_byte);
      if (out_valid && out_ready) begin
        got.status        = status_t'(out_status);
        got.sw_version    = out_sw_version;
        got.hw_version    = out_hw_version;
        got.stored_crc    = out_stored_crc;
        got.computed_crc  = out_computed_crc;
        got.padding_count = out_padding_count;
        got.packed_count  = out_packed_count;
        verdicts.match_verdict(got);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: drop out_ready at random, and once hold it low for a long stretch
  // so the output register fills and in_ready backs up while the sender pushes.
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles in front; return at the falling
  // edge after it is accepted. Valid holds high until the handshake.
  task automatic send_beat(input image_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_packed_byte   <= b.pb;
    in_original_byte <= b.ob;
    in_final_byte    <= b.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_image();
    foreach (image_beats[i]) send_beat(image_beats[i]);
  endtask

  // One APB transfer: setup cycle, access cycle, complete when pready is seen
  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write original_length, mirror it in the predictor, and read it back
  task automatic program_length(input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b1, ORIG_LEN_ADDR, CFG_DATA_W'(len), rd);
    verdicts.orig_len = len;
    apb_access(1'b0, ORIG_LEN_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(len)) verdicts.flag("original_length readback", 32'(len), rd);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Build one random image for the given payload length. Most images are well
  // formed with random content; some carry a bad CRC, a differing payload byte
  // or dirty padding (sometimes several at once to exercise precedence), and some
  // are cut short in the header or in the payload.
  function automatic void build_image(input logic [LEN_W-1:0] len);
    logic [7:0]       hdr [HDR_LEN];
    logic [7:0]       orig [32];
    logic [CRC_W-1:0] crc;
    logic [CRC_W-1:0] stored;
    logic [7:0]       pb;
    logic [7:0]       ob;
    int               n;
    int               plen;
    int               pad;
    int               r;
    int               diff_at;
    int               dirty_at;
    bit               crc_bad;
    bit               diff;
    bit               dirty;
    crc_bad = ($urandom_range(99) < 12);
    diff    = ($urandom_range(99) < 12);
    dirty   = ($urandom_range(99) < 12);
    plen    = (len > 31) ? 31 : int'(len);

    // Original payload and its CRC
    crc = CRC_INIT;
    for (int i = 0; i < plen; i++) begin
      orig[i] = 8'($urandom_range(255));
      crc     = crc32_step(crc, orig[i]);
    end
    crc    = crc ^ CRC_INIT;
    stored = crc_bad ? (crc ^ (32'd1 << $urandom_range(31))) : crc;

    // Header: random versions and date, CRC placed little-endian
    foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
    for (int k = 0; k < 4; k++) hdr[SC_AT+k] = stored[8*k +: 8];

    // Pick the image shape
    r   = $urandom_range(99);
    pad = 0;
    if (r >= 92 || (r >= 84 && len == 0)) begin
      n = $urandom_range(1, HDR_LEN - 1);
    end else if (r >= 84 || len > 16) begin
      n = HDR_LEN + $urandom_range(0, plen - 1);
    end else begin
      pad = $urandom_range(dirty ? 1 : 0, 4);
      n   = HDR_LEN + int'(len) + pad;
    end
    diff_at  = (diff && plen > 0) ? $urandom_range(0, plen - 1) : -1;
    dirty_at = (pad > 0 && dirty) ? HDR_LEN + int'(len) + $urandom_range(0, pad - 1) : -1;

    image_beats = {};
    for (int pos = 0; pos < n; pos++) begin
      ob = 8'($urandom_range(255));
      if (pos < HDR_LEN) begin
        pb = hdr[pos];
      end else if (pos < HDR_LEN + int'(len)) begin
        ob = orig[pos - HDR_LEN];
        pb = (pos - HDR_LEN == diff_at) ? (ob ^ 8'($urandom_range(1, 255))) : ob;
      end else begin
        pb = (pos == dirty_at) ? 8'($urandom_range(1, 255)) : 8'd0;
      end
      image_beats.push_back('{pb, ob, (pos == n - 1)});
    end
  endfunction

  initial begin
    logic [LEN_W-1:0] phase_len [PHASES];
    logic [CRC_W-1:0] crc1;
    int               phase_items;
    int               phase_images;
    logic [7:0]       pb;

    // Drive every input to a known value and hold reset
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_packed_byte   = '0;
    in_original_byte = '0;
    in_final_byte    = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    verdicts         = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset length of one payload byte.
    // A one-byte image: short header, only the count is reported.
    image_beats = {};
    image_beats.push_back('{8'hFF, 8'h00, 1'b1});
    send_image();

    // A full image: all-ones software version, alternating date bytes, correct
    // CRC of a single 0xFF payload byte, zero hardware version, one zero
    // padding byte. Original bytes swing between both extremes.
    crc1 = crc32_step(CRC_INIT, 8'hFF) ^ CRC_INIT;
    image_beats = {};
    for (int k = 0; k < HDR_LEN; k++) begin
      if (k < SC_AT)      pb = (k < 2 || k[0]) ? 8'hFF : 8'h00;
      else if (k < HW_AT) pb = crc1[8*(k - SC_AT) +: 8];
      else                pb = 8'h00;
      image_beats.push_back('{pb, (k[0] ? 8'h00 : 8'hFF), 1'b0});
    end
    image_beats.push_back('{8'hFF, 8'hFF, 1'b0});
    image_beats.push_back('{8'h00, 8'hFF, 1'b1});
    send_image();
    drain();

    // Random phases. Lengths include zero (no payload, CRC of nothing) and the
    // largest value, where every image ends short of its payload.
    phase_len = '{24'd0, 24'hFF_FFFF, 24'd1, 24'd0, 24'd0, 24'd16,
                  24'd0, 24'd0, 24'd0, 24'd0, 24'hFF_FFFF, 24'd0};
    foreach (phase_len[p])
      if (phase_len[p] == 0 && p != 0 && p != 7)
        phase_len[p] = LEN_W'($urandom_range(2, 15));

    for (int p = 0; p < PHASES; p++) begin
      // Sender dense and receiver busy, then the reverse, then full rate
      if (p < 4) begin
        send_idle_pct = 18;
        recv_idle_pct = 86;
      end else if (p < 8) begin
        send_idle_pct = 86;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Back up the block once while the sender runs flat out
      if (p == 8) hold_req = 1'b1;

      program_length(phase_len[p]);
      phase_items  = 0;
      phase_images = 0;
      while (phase_items < PHASE_BEATS || phase_images < MIN_IMAGES) begin
        build_image(phase_len[p]);
        phase_items += image_beats.size();
        phase_images++;
        send_image();
      end
      drain();
    end

    if (verdicts.mismatches == 0 && verdicts.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ firmware_image_verifier.f @@
sv/fiv_pkg.sv
sv/fiv_core.sv
sv/firmware_image_verifier.sv
verif/tb.sv
